// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while reset is low
`define RTT_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// property checked at every edge, reset included
`define RTT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rtt_pkg.sv =====
// ----------------------------------------------------------------------------
// rtt_pkg
// types, codes and constants of the repeating timer table
// ----------------------------------------------------------------------------
package rtt_pkg;

   localparam int RTT_SLOTS  = 16;
   localparam int TIME_BITS  = 48;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int ID_W       = 32;
   localparam int DT_W       = 16;
   localparam int PERIOD_W   = 32;
   localparam int COUNT_W    = 16;
   localparam int DELAY_W    = 32;
   localparam int ELAPSED_W  = 48;
   localparam int MAX_FIRES  = 16;
   localparam int FIRE_CNT_W = $clog2(MAX_FIRES);

   localparam logic [ID_W-1:0] NO_ID = {ID_W{1'b1}};

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK    = 2'd0,
      KIND_SCHED   = 2'd1,
      KIND_UNSCHED = 2'd2
   } rtt_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_FIRED   = 3'd0,
      ST_SCHED   = 3'd1,
      ST_REJECT  = 3'd2,
      ST_FULL    = 3'd3,
      ST_REMOVED = 3'd4,
      ST_ABSENT  = 3'd5
   } rtt_status_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [DT_W-1:0]     dt;
      logic [PERIOD_W-1:0] interval;
      logic [COUNT_W-1:0]  repeat_count;
      logic [DELAY_W-1:0]  delay;
      logic [ID_W-1:0]     target_id;
   } rtt_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [ID_W-1:0]      timer_id;
      logic [ELAPSED_W-1:0] elapsed;
      logic                 last;
   } rtt_rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]      id;
      logic [TIME_BITS-1:0] last_call;
      logic [TIME_BITS-1:0] deadline;
      logic [PERIOD_W-1:0]  period;
      logic [COUNT_W-1:0]   remaining;
   } rtt_entry_type;

   typedef enum logic {
      SCAN_ORDER,
      SCAN_MATCH
   } rtt_scan_mode_type;

   typedef struct packed {
      logic              clear;
      logic              update;
      rtt_scan_mode_type mode;
      logic              have_prev;
   } rtt_scan_ctl_type;

   typedef struct packed {
      logic best_found;
      logic second_found;
   } rtt_scan_sts_type;

endpackage

// ===== rtl/rtt_slot_mem.sv =====
// ----------------------------------------------------------------------------
// rtt_slot_mem
// slot record memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module rtt_slot_mem
   import rtt_pkg::*;
#(
   parameter int  SLOTS = RTT_SLOTS,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  rtt_entry_type wr_data,
   input  logic          rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output rtt_entry_type rd_data
);

   rtt_entry_type mem_ff [SLOTS];
   rtt_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rtt_scan.sv =====
// ----------------------------------------------------------------------------
// rtt_scan
// tracks the lowest and second lowest due id, or an id match, over one pass
// ----------------------------------------------------------------------------
module rtt_scan
   import rtt_pkg::*;
#(
   parameter int  SLOTS = RTT_SLOTS,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rtt_scan_ctl_type     ctl,
   input  logic [ID_W-1:0]      key,
   input  logic [TIME_BITS-1:0] timeline,
   input  rtt_entry_type        ent,
   input  logic                 ent_valid,
   input  logic [IDX_W-1:0]     ent_idx,
   output rtt_scan_sts_type     sts,
   output logic [IDX_W-1:0]     best_idx,
   output rtt_entry_type        best_ent
);

   logic             best_found_ff;
   logic             second_found_ff;
   logic [ID_W-1:0]  second_id_ff;
   logic [IDX_W-1:0] best_idx_ff;
   rtt_entry_type    best_ent_ff;

   logic due;
   logic hit;
   logic cand;
   logic take_best;
   logic take_second;

   always_comb begin
      due  = ent_valid && (timeline > ent.deadline) &&
             (!ctl.have_prev || (ent.id > key));
      hit  = ent_valid && (ent.id == key);
      cand = (ctl.mode == SCAN_ORDER) ? due : hit;
      take_best   = cand && (!best_found_ff ||
                    ((ctl.mode == SCAN_ORDER) && (ent.id < best_ent_ff.id)));
      take_second = cand && !take_best &&
                    (!second_found_ff || (ent.id < second_id_ff));
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         best_found_ff   <= 1'b0;
         second_found_ff <= 1'b0;
      end else if (ctl.update) begin
         if (take_best) begin
            best_found_ff   <= 1'b1;
            second_found_ff <= best_found_ff;
         end else if (take_second) begin
            second_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.update) begin
         if (take_best) begin
            best_ent_ff  <= ent;
            best_idx_ff  <= ent_idx;
            second_id_ff <= best_ent_ff.id;
         end else if (take_second) begin
            second_id_ff <= ent.id;
         end
      end
   end

   assign sts.best_found   = best_found_ff;
   assign sts.second_found = second_found_ff;
   assign best_idx         = best_idx_ff;
   assign best_ent         = best_ent_ff;

endmodule

// ===== rtl/rtt_seq.sv =====
// ----------------------------------------------------------------------------
// rtt_seq
// request sequencer: timeline, id counter, valid bits, scan passes and
// read-modify-write of slot records, with the result register
// ----------------------------------------------------------------------------
module rtt_seq
   import rtt_pkg::*;
#(
   parameter int  SLOTS = RTT_SLOTS,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rtt_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rtt_rsp_type          rsp_data,
   output logic                 wr_en,
   output logic [IDX_W-1:0]     wr_addr,
   output rtt_entry_type        wr_data,
   output logic                 rd_en,
   output logic [IDX_W-1:0]     rd_addr,
   output rtt_scan_ctl_type     scan_ctl,
   output logic [ID_W-1:0]      scan_key,
   output logic [TIME_BITS-1:0] timeline,
   output logic                 ent_valid,
   output logic [IDX_W-1:0]     ent_idx,
   input  rtt_scan_sts_type     scan_sts,
   input  logic [IDX_W-1:0]     best_idx,
   input  rtt_entry_type        best_ent
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_RESP
   } state_type;

   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
   endfunction

   state_type            state_ff, state_in;
   rtt_kind_type         op_ff, op_in;
   logic [TIME_BITS-1:0] timeline_ff, timeline_in;
   logic [ID_W-1:0]      next_id_ff, next_id_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [ID_W-1:0]      key_ff, key_in;
   logic                 have_prev_ff, have_prev_in;
   logic [IDX_W-1:0]     scan_addr_ff, scan_addr_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [FIRE_CNT_W-1:0] fire_cnt_ff, fire_cnt_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   rtt_entry_type        new_ent_ff, new_ent_in;
   logic [STATUS_W-1:0]  pend_status_ff, pend_status_in;
   logic [ID_W-1:0]      pend_id_ff, pend_id_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rtt_rsp_type          rsp_data_ff, rsp_data_in;

   logic             any_free;
   logic [IDX_W-1:0] free_idx;
   logic             out_free;
   logic [COUNT_W-1:0] fire_rem;
   logic             fire_done;
   logic             fire_last;
   rtt_entry_type    fire_ent;

   // lowest free slot
   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            any_free = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   // updated record of the slot that fires
   always_comb begin
      fire_rem  = best_ent.remaining - COUNT_W'(1);
      fire_done = (fire_rem == '0);
      fire_last = !scan_sts.second_found ||
                  (fire_cnt_ff == FIRE_CNT_W'(MAX_FIRES - 1));
      fire_ent           = best_ent;
      fire_ent.last_call = best_ent.deadline;
      fire_ent.remaining = fire_rem;
      if (!fire_done) begin
         fire_ent.deadline = sat_add(timeline_ff, TIME_BITS'(best_ent.period));
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      timeline_in    = timeline_ff;
      next_id_in     = next_id_ff;
      valid_in       = valid_ff;
      key_in         = key_ff;
      have_prev_in   = have_prev_ff;
      scan_addr_in   = scan_addr_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = scan_addr_ff;
      fire_cnt_in    = fire_cnt_ff;
      free_idx_in    = free_idx_ff;
      new_ent_in     = new_ent_ff;
      pend_status_in = pend_status_ff;
      pend_id_in     = pend_id_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      wr_en          = 1'b0;
      wr_addr        = best_idx;
      wr_data        = fire_ent;
      rd_en          = 1'b0;
      rd_addr        = scan_addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               scan_addr_in = '0;
               unique case (req_data.kind)
                  KIND_TICK: begin
                     op_in        = KIND_TICK;
                     timeline_in  = sat_add(timeline_ff, TIME_BITS'(req_data.dt));
                     have_prev_in = 1'b0;
                     fire_cnt_in  = '0;
                     state_in     = S_SCAN;
                  end
                  KIND_SCHED: begin
                     op_in = KIND_SCHED;
                     if (req_data.interval == '0) begin
                        pend_status_in = ST_REJECT;
                        pend_id_in     = NO_ID;
                        state_in       = S_RESP;
                     end else if (!any_free) begin
                        pend_status_in = ST_FULL;
                        pend_id_in     = NO_ID;
                        state_in       = S_RESP;
                     end else begin
                        key_in               = next_id_ff;
                        next_id_in           = next_id_ff + ID_W'(1);
                        free_idx_in          = free_idx;
                        new_ent_in.id        = next_id_ff;
                        new_ent_in.last_call = timeline_ff;
                        new_ent_in.deadline  = sat_add(timeline_ff,
                                                       TIME_BITS'(req_data.delay));
                        new_ent_in.period    = req_data.interval;
                        new_ent_in.remaining = (req_data.repeat_count == '0) ?
                                               COUNT_W'(1) : req_data.repeat_count;
                        have_prev_in         = 1'b0;
                        state_in             = S_SCAN;
                     end
                  end
                  KIND_UNSCHED: begin
                     op_in        = KIND_UNSCHED;
                     key_in       = req_data.target_id;
                     have_prev_in = 1'b0;
                     state_in     = S_SCAN;
                  end
                  default: begin
                     // unused kind: dropped
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            rd_en     = 1'b1;
            rd_vld_in = 1'b1;
            if (scan_addr_ff == IDX_W'(SLOTS - 1)) begin
               state_in = S_DRAIN;
            end else begin
               scan_addr_in = scan_addr_ff + IDX_W'(1);
            end
         end

         S_DRAIN: begin
            state_in = S_DECIDE;
         end

         S_DECIDE: begin
            unique case (op_ff)
               KIND_TICK: begin
                  if (!scan_sts.best_found) begin
                     state_in = S_IDLE;
                  end else if (out_free) begin
                     wr_en                = 1'b1;
                     rsp_valid_in         = 1'b1;
                     rsp_data_in.status   = ST_FIRED;
                     rsp_data_in.timer_id = best_ent.id;
                     rsp_data_in.elapsed  = ELAPSED_W'(best_ent.deadline - best_ent.last_call);
                     rsp_data_in.last     = fire_last;
                     if (fire_done) begin
                        valid_in[best_idx] = 1'b0;
                     end
                     fire_cnt_in  = fire_cnt_ff + FIRE_CNT_W'(1);
                     key_in       = best_ent.id;
                     have_prev_in = 1'b1;
                     scan_addr_in = '0;
                     state_in     = fire_last ? S_IDLE : S_SCAN;
                  end
               end
               KIND_SCHED: begin
                  if (out_free) begin
                     // id still held by a live timer after wrap: report only
                     if (!scan_sts.best_found) begin
                        wr_en                 = 1'b1;
                        wr_addr               = free_idx_ff;
                        wr_data               = new_ent_ff;
                        valid_in[free_idx_ff] = 1'b1;
                     end
                     rsp_valid_in         = 1'b1;
                     rsp_data_in.status   = ST_SCHED;
                     rsp_data_in.timer_id = key_ff;
                     rsp_data_in.elapsed  = '0;
                     rsp_data_in.last     = 1'b1;
                     state_in             = S_IDLE;
                  end
               end
               KIND_UNSCHED: begin
                  if (out_free) begin
                     if (scan_sts.best_found) begin
                        valid_in[best_idx] = 1'b0;
                     end
                     rsp_valid_in         = 1'b1;
                     rsp_data_in.status   = scan_sts.best_found ? ST_REMOVED : ST_ABSENT;
                     rsp_data_in.timer_id = key_ff;
                     rsp_data_in.elapsed  = '0;
                     rsp_data_in.last     = 1'b1;
                     state_in             = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_RESP: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.status   = pend_status_ff;
               rsp_data_in.timer_id = pend_id_ff;
               rsp_data_in.elapsed  = '0;
               rsp_data_in.last     = 1'b1;
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         timeline_ff  <= '0;
         next_id_ff   <= '0;
         valid_ff     <= '0;
         have_prev_ff <= 1'b0;
         scan_addr_ff <= '0;
         rd_vld_ff    <= 1'b0;
         fire_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timeline_ff  <= timeline_in;
         next_id_ff   <= next_id_in;
         valid_ff     <= valid_in;
         have_prev_ff <= have_prev_in;
         scan_addr_ff <= scan_addr_in;
         rd_vld_ff    <= rd_vld_in;
         fire_cnt_ff  <= fire_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      key_ff         <= key_in;
      rd_idx_ff      <= rd_idx_in;
      free_idx_ff    <= free_idx_in;
      new_ent_ff     <= new_ent_in;
      pend_status_ff <= pend_status_in;
      pend_id_ff     <= pend_id_in;
      rsp_data_ff    <= rsp_data_in;
   end

   always_comb begin
      scan_ctl.clear     = (state_ff == S_SCAN) && (scan_addr_ff == '0);
      scan_ctl.update    = rd_vld_ff;
      scan_ctl.mode      = (op_ff == KIND_TICK) ? SCAN_ORDER : SCAN_MATCH;
      scan_ctl.have_prev = have_prev_ff;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign scan_key  = key_ff;
   assign timeline  = timeline_ff;
   assign ent_valid = valid_ff[rd_idx_ff];
   assign ent_idx   = rd_idx_ff;

endmodule

// ===== rtl/repeating_timer_table_top.sv =====
// ----------------------------------------------------------------------------
// repeating_timer_table_top
// table of repeating timers on an integer tick timeline
// ----------------------------------------------------------------------------
// The slot records live in a single-port-read memory, so a request walks
// the table one slot per cycle: a schedule or unschedule request walks it once
// (a schedule refused for a zero interval or a full table does not walk it),
// and a tick walks it once when nothing is due and once per fired timer
// otherwise, since each pass picks the next due timer in ascending id order;
// at most MAX_FIRES timers fire per tick. One request is in work at a time;
// a new request is taken while the last result still waits in the output
// register. Stalls on rsp_ready delay each result that is waiting to go out.
module repeating_timer_table_top
   import rtt_pkg::*;
#(
   parameter int SLOTS = RTT_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  rtt_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rtt_rsp_type rsp_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   rtt_entry_type        wr_data;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   rtt_entry_type        rd_data;
   rtt_scan_ctl_type     scan_ctl;
   logic [ID_W-1:0]      scan_key;
   logic [TIME_BITS-1:0] timeline;
   logic                 ent_valid;
   logic [IDX_W-1:0]     ent_idx;
   rtt_scan_sts_type     scan_sts;
   logic [IDX_W-1:0]     best_idx;
   rtt_entry_type        best_ent;

   rtt_slot_mem #(.SLOTS(SLOTS)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rtt_scan #(.SLOTS(SLOTS)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .key       (scan_key),
      .timeline  (timeline),
      .ent       (rd_data),
      .ent_valid (ent_valid),
      .ent_idx   (ent_idx),
      .sts       (scan_sts),
      .best_idx  (best_idx),
      .best_ent  (best_ent)
   );

   rtt_seq #(.SLOTS(SLOTS)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .scan_ctl  (scan_ctl),
      .scan_key  (scan_key),
      .timeline  (timeline),
      .ent_valid (ent_valid),
      .ent_idx   (ent_idx),
      .scan_sts  (scan_sts),
      .best_idx  (best_idx),
      .best_ent  (best_ent)
   );

endmodule

// ===== rtl/rtt_checker.sv =====
// ----------------------------------------------------------------------------
// rtt_checker
// port-level checks of the repeating timer table, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtt_checker
   import rtt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input rtt_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input rtt_rsp_type rsp_data
);

   logic known_kind;
   logic not_fired;
   logic refused;
   logic refusal_ok;

   assign known_kind = (req_data.kind == KIND_TICK) || (req_data.kind == KIND_SCHED) ||
                       (req_data.kind == KIND_UNSCHED);
   assign not_fired  = (rsp_data.status != ST_FIRED);
   assign refused    = (rsp_data.status == ST_REJECT) || (rsp_data.status == ST_FULL);
   assign refusal_ok = (rsp_data.timer_id == NO_ID) && (rsp_data.elapsed == '0);

   // no result comes out right after reset
   `RTT_ASSERT_RST(a_reset_quiet, clock, reset, $past(reset) |-> !rsp_valid, "result after reset")

   // only fire results may leave the sequence open
   `RTT_ASSERT_RST(a_single_last, clock, reset, rsp_valid && not_fired |-> rsp_data.last, "open result")

   // refused schedules carry no id and no elapsed time
   `RTT_ASSERT_RST(a_refusal_id, clock, reset, rsp_valid && refused |-> refusal_ok, "bad refusal")

   // a real request leaves the block busy in the cycle after it is taken
   `RTT_ASSERT_RST(a_busy_after_req, clock, reset, req_valid && req_ready && known_kind |=> !req_ready, "ready after request")

   `RTT_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind repeating_timer_table_top rtt_checker u_rtt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== test/timer_table_checker.sv =====
// ----------------------------------------------------------------------------
// timer_table_checker
// watches both channels of the timer table, predicts every result from its
// own copy of the slot table and compares each returned result field by field
// ----------------------------------------------------------------------------
module timer_table_checker
   import rtt_pkg::*;
#(
   parameter int SLOTS = RTT_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  rtt_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rtt_rsp_type rsp_data,
   output int          pending,
   output int          fail_count
);

   // shadow of the timer table
   logic [TIME_BITS-1:0] timeline_now;
   logic [ID_W-1:0]      id_next;
   logic                 slot_live [SLOTS];
   rtt_entry_type        slot_rec  [SLOTS];

   rtt_rsp_type timer_events_q [$];
   rtt_rsp_type oldest_event;

   initial begin
      timeline_now = '0;
      id_next      = '0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_live[i] = 1'b0;
         slot_rec[i]  = '0;
      end
      pending    = 0;
      fail_count = 0;
   end

   function automatic logic [TIME_BITS-1:0] sat_sum(input logic [TIME_BITS-1:0] a,
                                                    input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
   endfunction

   function automatic rtt_rsp_type make_event(input rtt_status_type st,
                                              input logic [ID_W-1:0] id,
                                              input logic [ELAPSED_W-1:0] el,
                                              input logic lst);
      rtt_rsp_type e;
      e.status   = st;
      e.timer_id = id;
      e.elapsed  = el;
      e.last     = lst;
      return e;
   endfunction

   // append one expected result at the tail of the queue
   function automatic void post_event(input rtt_rsp_type e);
      timer_events_q = {timer_events_q, e};
   endfunction

   function automatic int slot_of_id(input logic [ID_W-1:0] id);
      for (int i = 0; i < SLOTS; i++)
         if (slot_live[i] && slot_rec[i].id == id)
            return i;
      return -1;
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      fail_count++;
      $display("mismatch on %s: got %0h, want %0h", what, got, want);
   endtask

   // walk the valid slots in ascending id order, firing each overdue one, up to MAX_FIRES
   task automatic advance_timeline(input logic [DT_W-1:0] dt);
      int               fired;
      int               best;
      logic             have_prev;
      logic [ID_W-1:0]  prev_id;
      logic             have_held;
      rtt_rsp_type      held;
      fired     = 0;
      have_prev = 1'b0;
      prev_id   = '0;
      have_held = 1'b0;
      held      = '0;
      timeline_now = sat_sum(timeline_now, {{(TIME_BITS-DT_W){1'b0}}, dt});
      while (fired < MAX_FIRES) begin
         best = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i] && !(have_prev && slot_rec[i].id <= prev_id))
               if (best < 0 || slot_rec[i].id < slot_rec[best].id)
                  best = i;
         end
         if (best < 0)
            break;
         prev_id   = slot_rec[best].id;
         have_prev = 1'b1;
         if (timeline_now > slot_rec[best].deadline) begin
            if (have_held)
               post_event(held);
            held = make_event(ST_FIRED, slot_rec[best].id,
                              slot_rec[best].deadline - slot_rec[best].last_call, 1'b0);
            have_held = 1'b1;
            fired++;
            slot_rec[best].last_call = slot_rec[best].deadline;
            slot_rec[best].remaining = slot_rec[best].remaining - 1'b1;
            if (slot_rec[best].remaining == '0)
               slot_live[best] = 1'b0;
            else
               slot_rec[best].deadline = sat_sum(timeline_now,
                  {{(TIME_BITS-PERIOD_W){1'b0}}, slot_rec[best].period});
         end
      end
      if (have_held) begin
         held.last = 1'b1;
         post_event(held);
      end
   endtask

   task automatic add_timer(input rtt_req_type r);
      int              free_slot;
      logic [ID_W-1:0] id;
      free_slot = -1;
      if (r.interval == '0) begin
         post_event(make_event(ST_REJECT, NO_ID, '0, 1'b1));
         return;
      end
      for (int i = SLOTS - 1; i >= 0; i--)
         if (!slot_live[i])
            free_slot = i;
      if (free_slot < 0) begin
         post_event(make_event(ST_FULL, NO_ID, '0, 1'b1));
         return;
      end
      id      = id_next;
      id_next = id_next + 1'b1;
      // an id still held after wrap leaves the old timer alone
      if (slot_of_id(id) < 0) begin
         slot_live[free_slot]          = 1'b1;
         slot_rec[free_slot].id        = id;
         slot_rec[free_slot].period    = r.interval;
         slot_rec[free_slot].remaining = (r.repeat_count == '0) ? 16'd1 : r.repeat_count;
         slot_rec[free_slot].last_call = timeline_now;
         slot_rec[free_slot].deadline  = sat_sum(timeline_now,
            {{(TIME_BITS-DELAY_W){1'b0}}, r.delay});
      end
      post_event(make_event(ST_SCHED, id, '0, 1'b1));
   endtask

   task automatic drop_timer(input logic [ID_W-1:0] target);
      int s;
      s = slot_of_id(target);
      if (s < 0) begin
         post_event(make_event(ST_ABSENT, target, '0, 1'b1));
      end else begin
         slot_live[s] = 1'b0;
         post_event(make_event(ST_REMOVED, target, '0, 1'b1));
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (timer_events_q.size() == 0) begin
               flag_mismatch("result with nothing outstanding",
                             64'(rsp_data.timer_id), '0);
            end else begin
               oldest_event = timer_events_q.pop_front();
               if (rsp_data.status !== oldest_event.status)
                  flag_mismatch("status", 64'(rsp_data.status),
                                64'(oldest_event.status));
               if (rsp_data.timer_id !== oldest_event.timer_id)
                  flag_mismatch("timer_id", 64'(rsp_data.timer_id),
                                64'(oldest_event.timer_id));
               if (rsp_data.elapsed !== oldest_event.elapsed)
                  flag_mismatch("elapsed", 64'(rsp_data.elapsed),
                                64'(oldest_event.elapsed));
               if (rsp_data.last !== oldest_event.last)
                  flag_mismatch("last", 64'(rsp_data.last), 64'(oldest_event.last));
            end
         end
         if (req_valid && req_ready) begin
            case (req_data.kind)
               KIND_TICK:    advance_timeline(req_data.dt);
               KIND_SCHED:   add_timer(req_data);
               KIND_UNSCHED: drop_timer(req_data.target_id);
               default:      ;
            endcase
         end
      end
      pending <= timer_events_q.size();
   end

endmodule

// ===== test/repeating_timer_table_top_tb.sv =====
// ----------------------------------------------------------------------------
// repeating_timer_table_top_tb
// drives ticks, schedules and unschedules into the timer table with random
// gaps and stalls on both channels; the checker predicts and compares results
// ----------------------------------------------------------------------------
module repeating_timer_table_top_tb;
   import rtt_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 400;
   localparam int LONG_HOLD = 400;
   localparam int RANDOM_REQUESTS = 246;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   rtt_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rtt_rsp_type rsp_data;

   int   pending;
   int   fail_count;
   int   cycles = 0;
   logic quiet = 1'b0;
   logic hold_go = 1'b0;
   logic gaps_on;
   int   sched_sent;

   repeating_timer_table_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   timer_table_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .pending    (pending),
      .fail_count (fail_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // unused fields of every request carry random noise
   function automatic rtt_req_type noise_req();
      rtt_req_type r;
      r.kind         = KIND_TICK;
      r.dt           = DT_W'($urandom);
      r.interval     = $urandom;
      r.repeat_count = COUNT_W'($urandom);
      r.delay        = $urandom;
      r.target_id    = $urandom;
      return r;
   endfunction

   function automatic rtt_req_type tick_req(input logic [DT_W-1:0] dt);
      rtt_req_type r;
      r      = noise_req();
      r.kind = KIND_TICK;
      r.dt   = dt;
      return r;
   endfunction

   function automatic rtt_req_type sched_req(input logic [PERIOD_W-1:0] interval,
                                             input logic [COUNT_W-1:0] rep,
                                             input logic [DELAY_W-1:0] delay);
      rtt_req_type r;
      r              = noise_req();
      r.kind         = KIND_SCHED;
      r.interval     = interval;
      r.repeat_count = rep;
      r.delay        = delay;
      return r;
   endfunction

   function automatic rtt_req_type unsched_req(input logic [ID_W-1:0] target);
      rtt_req_type r;
      r           = noise_req();
      r.kind      = KIND_UNSCHED;
      r.target_id = target;
      return r;
   endfunction

   // one request: an optional idle burst, then hold valid until accepted
   task automatic send_request(input rtt_req_type r);
      if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      if (r.kind == KIND_SCHED)
         sched_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic rtt_req_type random_req();
      int          pick;
      rtt_req_type r;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         r = tick_req(($urandom_range(0, 9) == 0) ? DT_W'($urandom)
                                                  : DT_W'($urandom_range(0, 200)));
      end else if (pick < 75) begin
         r = sched_req(($urandom_range(0, 19) == 0) ? '0 :
                       ($urandom_range(0, 9) == 0) ? PERIOD_W'($urandom)
                                                   : PERIOD_W'($urandom_range(1, 150)),
                       ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom)
                                                   : COUNT_W'($urandom_range(0, 6)),
                       ($urandom_range(0, 9) == 0) ? DELAY_W'($urandom)
                                                   : DELAY_W'($urandom_range(0, 200)));
      end else if (pick < 95) begin
         r = unsched_req(($urandom_range(0, 6) == 0) ? ID_W'($urandom)
                                                     : ID_W'($urandom_range(0, sched_sent + 1)));
      end else begin
         r      = noise_req();
         r.kind = KIND_SPARE;
      end
      return r;
   endfunction

   // receiver: random stall bursts, stretches without stalls, one long hold-off
   initial begin
      int   stall;
      int   rx_cycles;
      logic held;
      stall     = 0;
      rx_cycles = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         rx_cycles++;
         if (hold_go && !held) begin
            held  = 1'b1;
            stall = LONG_HOLD;
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (!quiet && (rx_cycles % 1000) < 700 && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 11) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      rtt_req_type r;
      int          sent;
      gaps_on    = 1'b1;
      sched_sent = 0;
      sent       = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_request(tick_req('0));                    // nothing due, no result
      send_request(sched_req('0, COUNT_W'($urandom), $urandom)); // zero interval
      send_request(sched_req('1, '1, '1));
      send_request(unsched_req('0));
      send_request(unsched_req('1));                 // unknown id
      r      = noise_req();
      r.kind = KIND_SPARE;
      send_request(r);
      // fill every slot, overflow once, then fire the whole table in one tick
      for (int i = 0; i < RTT_SLOTS; i++)
         send_request(sched_req(i + 1, (i % 2) ? 16'd2 : 16'd0, i));
      send_request(sched_req(7, 1, 0));
      send_request(tick_req('1));
      send_request(tick_req('1));

      while (sent < RANDOM_REQUESTS) begin
         r = random_req();
         send_request(r);
         if (r.kind != KIND_SPARE) begin
            sent++;
            gaps_on = (sent % 60) < 40;
            if (sent == 80)
               hold_go <= 1'b1;
            if (sent == 160) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
            if (sent == RANDOM_REQUESTS - 40)
               quiet <= 1'b1;
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
